/* sv/slist_pkg.sv */
// Shared types and codes for the sorted integer list.
`default_nettype none
package slist_pkg;

  // Operation codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_NO_LIST   = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_LAST_KEPT = 3'd4
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    FSM_IDLE   = 3'd0,
    FSM_SCAN   = 3'd1,
    FSM_SHIFT  = 3'd2,
    FSM_INSERT = 3'd3,
    FSM_PLACE  = 3'd4
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] entry_count;
  } out_item_t;

endpackage
`default_nettype wire

/* sv/sorted_integer_list.sv */
// Top level of the sorted integer list: sequencer plus cell RAM.
//
//   channel  ports                     transfer
//   input    start, busy, in_item      rising edge with start high, busy low
//   result   out_valid, out_item       rising edge ending the one-cycle strobe
//
// Create and a failed insert are done in idle; the result strobe follows the
// last working cycle. Insert moves entries not below the value up from the
// tail, then writes the value, search scans one entry per cycle up to the match,
// and remove scans to the match then moves count-pos-1 entries, one per cycle.
// This pacing comes from the single read and write port of the cell RAM.
// Reset clears count and the list flag; the cell RAM needs no clearing.
// The receiver cannot stall: busy alone holds off new operations.
`default_nettype none
module sorted_integer_list #(
  parameter int CAPACITY = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire slist_pkg::in_item_t  in_item,
  output logic                      out_valid,
  output slist_pkg::out_item_t      out_item
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  // Sequence operations
  slist_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Hold the list cells
  slist_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

/* sv/slist_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module slist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read with registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/slist_ctrl.sv */
// Sequencer that scans, shifts and inserts list entries through the cell RAM.
`default_nettype none
module slist_ctrl #(
  parameter int CAPACITY = 16,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire slist_pkg::in_item_t  in_item,
  output logic                      out_valid,
  output slist_pkg::out_item_t      out_item,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [31:0]               mem_wdata,
  output logic [AW-1:0]             mem_raddr,
  input  wire logic [31:0]          mem_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  slist_pkg::state_t    state_r, state_nxt;
  slist_pkg::kind_t     kind_r, kind_nxt;
  logic signed [31:0]   value_r, value_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 exists_r, exists_nxt;
  logic                 out_valid_r, out_valid_nxt;
  slist_pkg::out_item_t out_item_r, out_item_nxt;
  slist_pkg::status_t   status;
  logic                 emit;

  logic [CW-1:0]      cnt_m1, idx_m1, idx_m2, idx_p1, idx_p2;
  logic signed [31:0] rd_val;

  assign cnt_m1 = count_r - ONE_C;
  assign idx_m1 = idx_r - ONE_C;
  assign idx_m2 = idx_r - CW'(2);
  assign idx_p1 = idx_r + ONE_C;
  assign idx_p2 = idx_r + CW'(2);
  assign rd_val = $signed(mem_rdata);

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slist_pkg::FSM_IDLE;
      count_r     <= '0;
      exists_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      exists_r    <= exists_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold operands, walking index and the result payload
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    value_r    <= value_nxt;
    idx_r      <= idx_nxt;
    out_item_r <= out_item_nxt;
  end

  // Next state, RAM access and result
  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    value_nxt  = value_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    exists_nxt = exists_r;
    emit       = 1'b0;
    status     = slist_pkg::STAT_OK;
    mem_we     = 1'b0;
    mem_waddr  = idx_r[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = '0;
    unique case (state_r)
      slist_pkg::FSM_IDLE: begin
        if (start) begin
          kind_nxt  = in_item.kind;
          value_nxt = in_item.value;
          unique case (in_item.kind)
            slist_pkg::KIND_CREATE: begin
              mem_we     = 1'b1;
              mem_waddr  = '0;
              mem_wdata  = in_item.value;
              count_nxt  = ONE_C;
              exists_nxt = 1'b1;
              emit       = 1'b1;
            end
            slist_pkg::KIND_INSERT: begin
              if (!exists_r) begin
                status = slist_pkg::STAT_NO_LIST;
                emit   = 1'b1;
              end else if (count_r >= CAP_C) begin
                status = slist_pkg::STAT_FULL;
                emit   = 1'b1;
              end else begin
                mem_raddr = cnt_m1[AW-1:0];
                idx_nxt   = count_r;
                state_nxt = slist_pkg::FSM_INSERT;
              end
            end
            slist_pkg::KIND_SEARCH, slist_pkg::KIND_REMOVE: begin
              if (count_r == '0) begin
                status = slist_pkg::STAT_NOT_FOUND;
                emit   = 1'b1;
              end else begin
                mem_raddr = '0;
                idx_nxt   = '0;
                state_nxt = slist_pkg::FSM_SCAN;
              end
            end
          endcase
        end
      end
      slist_pkg::FSM_SCAN: begin
        // Compare entry idx; fetch the next one unless done
        if (rd_val == value_r) begin
          emit      = 1'b1;
          state_nxt = slist_pkg::FSM_IDLE;
          if (kind_r == slist_pkg::KIND_REMOVE) begin
            if (count_r == ONE_C) begin
              status = slist_pkg::STAT_LAST_KEPT;
            end else if (idx_p1 == count_r) begin
              count_nxt = cnt_m1;
            end else begin
              emit      = 1'b0;
              mem_raddr = idx_p1[AW-1:0];
              state_nxt = slist_pkg::FSM_SHIFT;
            end
          end
        end else if (idx_p1 == count_r) begin
          status    = slist_pkg::STAT_NOT_FOUND;
          emit      = 1'b1;
          state_nxt = slist_pkg::FSM_IDLE;
        end else begin
          mem_raddr = idx_p1[AW-1:0];
          idx_nxt   = idx_p1;
        end
      end
      slist_pkg::FSM_SHIFT: begin
        // Move entry idx+1 down to idx
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = idx_p1;
        if (idx_p2 == count_r) begin
          count_nxt = cnt_m1;
          emit      = 1'b1;
          state_nxt = slist_pkg::FSM_IDLE;
        end else begin
          mem_raddr = idx_p2[AW-1:0];
        end
      end
      slist_pkg::FSM_INSERT: begin
        // Entry idx-1 is in data: move it up or drop the value in at idx
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        if (rd_val >= value_r) begin
          mem_wdata = mem_rdata;
          idx_nxt   = idx_m1;
          if (idx_r == ONE_C) begin
            state_nxt = slist_pkg::FSM_PLACE;
          end else begin
            mem_raddr = idx_m2[AW-1:0];
          end
        end else begin
          mem_wdata = value_r;
          count_nxt = count_r + ONE_C;
          emit      = 1'b1;
          state_nxt = slist_pkg::FSM_IDLE;
        end
      end
      slist_pkg::FSM_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = value_r;
        count_nxt = count_r + ONE_C;
        emit      = 1'b1;
        state_nxt = slist_pkg::FSM_IDLE;
      end
      default: begin
        state_nxt = slist_pkg::FSM_IDLE;
      end
    endcase
    out_valid_nxt            = emit;
    out_item_nxt.status      = status;
    out_item_nxt.entry_count = 5'(count_nxt);
  end

  assign busy      = (state_r != slist_pkg::FSM_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

/* sv/slist_chk.sv */
// Port-level checker for the sorted integer list, bound to the top level.
`default_nettype none
module slist_chk #(
  parameter int CAPACITY = 16
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire slist_pkg::in_item_t  in_item,
  input wire logic                 out_valid,
  input wire slist_pkg::out_item_t out_item
);

  // Every transfer in either reports at once or starts work
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted operation neither reported nor started");

  // Create always reports ok with a single entry
  a_create_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind == slist_pkg::KIND_CREATE) |=>
      (out_valid && out_item.status == slist_pkg::STAT_OK &&
       out_item.entry_count == 5'd1))
    else $error("create did not report ok with one entry");

  // Finishing a multi-cycle operation always delivers a result
  a_finish_reports: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("operation finished without a result");

  // Count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_item.entry_count) <= 32'(CAPACITY)))
    else $error("entry count above capacity");

endmodule

bind sorted_integer_list slist_chk #(.CAPACITY(CAPACITY)) u_slist_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

/* verif/slist_checker.sv */
// Checker for the sorted integer list: predicts each result and compares it.
`timescale 1ns / 100ps
module slist_checker #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  slist_pkg::in_item_t  in_item,
  input  logic                 out_valid,
  input  slist_pkg::out_item_t out_item,
  output int                   fail_count,
  output int                   pending_count
);
  import slist_pkg::*;

  // Shadow copy of the list contents
  logic signed [31:0] list_cells [CAPACITY];
  int                 list_len;
  bit                 list_made;

  // Replies predicted for accepted operations, oldest first
  out_item_t pending_replies [$];

  // Apply one operation to the shadow list and return its reply
  function automatic out_item_t apply_list_op(in_item_t op);
    out_item_t reply;
    int        hit;
    int        pos;
    int        i;
    reply.status = STAT_OK;
    // Locate the first entry equal to the operand
    hit = list_len;
    for (i = list_len - 1; i >= 0; i--) begin
      if (list_cells[i] == op.value) hit = i;
    end
    case (op.kind)
      KIND_CREATE: begin
        list_cells[0] = op.value;
        list_len = 1;
        list_made = 1'b1;
      end
      KIND_INSERT: begin
        if (!list_made) begin
          reply.status = STAT_NO_LIST;
        end else if (list_len >= CAPACITY) begin
          reply.status = STAT_FULL;
        end else begin
          // Land ahead of any equal entries
          pos = 0;
          while (pos < list_len && list_cells[pos] < op.value) pos++;
          for (i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = op.value;
          list_len++;
        end
      end
      KIND_SEARCH: begin
        reply.status = (hit < list_len) ? STAT_OK : STAT_NOT_FOUND;
      end
      default: begin
        if (hit >= list_len) begin
          reply.status = STAT_NOT_FOUND;
        end else if (list_len == 1) begin
          reply.status = STAT_LAST_KEPT;
        end else begin
          for (i = hit; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
    endcase
    reply.entry_count = 5'(list_len);
    return reply;
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
    list_len      = 0;
    list_made     = 1'b0;
  end

  // Watch both channels; retire the oldest reply before queuing a new one
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      list_len  = 0;
      list_made = 1'b0;
      pending_replies.delete();
    end else begin
      if (out_valid) begin
        if (pending_replies.size() == 0) begin
          $error("unexpected result transfer: status %0d entry_count %0d",
                 out_item.status, out_item.entry_count);
          fail_count++;
        end else begin
          want = pending_replies.pop_front();
          if (out_item.status !== want.status) begin
            $error("field status: expected %0d, actual %0d",
                   want.status, out_item.status);
            fail_count++;
          end
          if (out_item.entry_count !== want.entry_count) begin
            $error("field entry_count: expected %0d, actual %0d",
                   want.entry_count, out_item.entry_count);
            fail_count++;
          end
        end
      end
      if (start && !busy) pending_replies.push_back(apply_list_op(in_item));
    end
    pending_count = pending_replies.size();
  end

endmodule

/* verif/tb_sorted_integer_list.sv */
// Testbench top for the sorted integer list: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb_sorted_integer_list;
  import slist_pkg::*;

  localparam int CAPACITY       = 16;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int POOL_SIZE      = 8;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending_count;
  int        stall_cycles;
  bit        no_idle;

  // Values sent recently, reused so that searches and removes hit
  logic signed [31:0] recent_vals [POOL_SIZE];

  sorted_integer_list #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  slist_checker #(.CAPACITY(CAPACITY)) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_item_t make_op(kind_t kind, logic signed [31:0] value);
    in_item_t op;
    op.kind  = kind;
    op.value = value;
    return op;
  endfunction

  // Present one operation from a falling edge and hold it until the transfer
  task automatic send_op(in_item_t op);
    while (!no_idle && $urandom_range(0, 99) < 26) begin
      start = 1'b0;
      @(negedge clk);
    end
    start   = 1'b1;
    in_item = op;
    if (op.kind == KIND_CREATE || op.kind == KIND_INSERT)
      recent_vals[$urandom_range(0, POOL_SIZE-1)] = op.value;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold the sender until every reply is in
  task automatic wait_quiet();
    start = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return recent_vals[$urandom_range(0, POOL_SIZE-1)];
    if (r < 65) begin
      case ($urandom_range(0, 4))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    if (r < 80) return $signed($urandom_range(0, 20)) - 32'sd10;
    return $signed($urandom());
  endfunction

  // Fill phases lean on inserts, drain phases on removes
  function automatic in_item_t pick_op(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return make_op(KIND_CREATE, pick_value());
    if (filling) begin
      if (r < 67) return make_op(KIND_INSERT, pick_value());
      if (r < 82) return make_op(KIND_SEARCH, pick_value());
    end else begin
      if (r < 22) return make_op(KIND_INSERT, pick_value());
      if (r < 42) return make_op(KIND_SEARCH, pick_value());
    end
    return make_op(KIND_REMOVE, pick_value());
  endfunction

  initial begin
    bit filling;
    int phase_left;
    int n;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    no_idle = 1'b0;
    stall_cycles = 0;
    for (n = 0; n < POOL_SIZE; n++) recent_vals[n] = $signed($urandom());
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Operations before any list exists
    send_op(make_op(KIND_SEARCH, 32'sd0));
    send_op(make_op(KIND_REMOVE, 32'sd5));
    send_op(make_op(KIND_INSERT, 32'sd7));
    // Single entry is never removed
    send_op(make_op(KIND_CREATE, 32'sd0));
    send_op(make_op(KIND_REMOVE, 32'sd0));
    send_op(make_op(KIND_INSERT, 32'sh7fff_ffff));
    send_op(make_op(KIND_INSERT, 32'sh8000_0000));
    send_op(make_op(KIND_INSERT, 32'sd0));
    send_op(make_op(KIND_SEARCH, 32'sh8000_0000));
    send_op(make_op(KIND_REMOVE, 32'sd5));
    send_op(make_op(KIND_REMOVE, 32'sh7fff_ffff));
    // Create over a live list, then fill it past capacity
    send_op(make_op(KIND_CREATE, -32'sd7));
    for (n = 1; n < CAPACITY; n++)
      send_op(make_op(KIND_INSERT, (n % 3 == 0) ? -32'sd7 :
                      (n % 2 == 1) ? 32'sd1000003 * n : -32'sd77 * n));
    send_op(make_op(KIND_INSERT, 32'sh7fff_ffff));
    wait_quiet();
    @(negedge clk);

    // Random traffic in fill and drain phases
    filling    = 1'b1;
    phase_left = 40;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 700 && n < 1000);
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      if (n % 300 == 299) begin
        wait_quiet();
        @(negedge clk);
      end
      send_op(pick_op(filling));
    end

    // Let the last replies arrive, then give the verdict
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/slist_pkg.sv
sv/slist_ram.sv
sv/slist_ctrl.sv
sv/sorted_integer_list.sv
sv/slist_chk.sv
verif/slist_checker.sv
verif/tb_sorted_integer_list.sv
